FILE: design/irp_pkg.sv
`default_nettype none

package irp_pkg;

  localparam int unsigned VAL_W      = 48;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned ETA_W      = 16;
  localparam int unsigned ETA_FRAC   = 14;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned PROD_W     = STEP_W + ETA_W;
  localparam int unsigned SCALED_W   = PROD_W - ETA_FRAC;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [ETA_W-1:0]  ETA_PLUS_RST  = 16'd19661;
  localparam logic [ETA_W-1:0]  ETA_MINUS_RST = 16'd8192;
  localparam logic [STEP_W-1:0] STEP_MIN_RST  = 32'd17;
  localparam logic [STEP_W-1:0] STEP_MAX_RST  = 32'd838860800;
  localparam logic [STEP_W-1:0] STEP_INIT_RST = 32'd1677722;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_UPDATE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    SIGN_ZERO = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_t;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_GROW,
    MODE_SHRINK
  } step_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ETA_PLUS  = 3'd0,
    CFG_ETA_MINUS = 3'd1,
    CFG_STEP_MIN  = 3'd2,
    CFG_STEP_MAX  = 3'd3,
    CFG_STEP_INIT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [ETA_W-1:0]  eta_plus;
    logic [ETA_W-1:0]  eta_minus;
    logic [STEP_W-1:0] step_min;
    logic [STEP_W-1:0] step_max;
    logic [STEP_W-1:0] step_init;
  } cfg_t;

  // one stored variable: value, step, previous sign code
  typedef struct packed {
    logic signed [VAL_W-1:0] var_val;
    logic [STEP_W-1:0]       step;
    logic [1:0]              sign_code;
  } entry_t;

  // per-stage tag that travels with a beat
  typedef struct packed {
    logic             valid;
    logic             wr;
    logic [IDX_W-1:0] idx;
  } item_ctl_t;

  function automatic sign_t sign_of(input logic signed [VAL_W-1:0] v);
    sign_t s;
    if (v == '0) begin
      s = SIGN_ZERO;
    end else if (v[VAL_W-1]) begin
      s = SIGN_NEG;
    end else begin
      s = SIGN_POS;
    end
    return s;
  endfunction

  // code three is never written; treat as zero
  function automatic sign_t sign_decode(input logic [1:0] code);
    sign_t s;
    case (code)
      SIGN_POS: s = SIGN_POS;
      SIGN_NEG: s = SIGN_NEG;
      default: s = SIGN_ZERO;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: design/irp_in_if.sv
`default_nettype none

interface irp_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [irp_pkg::IDX_W-1:0]           var_index;
  logic signed [irp_pkg::VAL_W-1:0]    operand_value;

  modport source (output valid, action, var_index, operand_value, input ready);
  modport sink (input valid, action, var_index, operand_value, output ready);
endinterface

`default_nettype wire

FILE: design/irp_out_if.sv
`default_nettype none

interface irp_out_if;
  logic                                valid;
  logic                                ready;
  logic [irp_pkg::IDX_W-1:0]           out_index;
  logic signed [irp_pkg::VAL_W-1:0]    variable_value;
  logic [irp_pkg::STEP_W-1:0]          step_size;

  modport source (output valid, out_index, variable_value, step_size, input ready);
  modport sink (input valid, out_index, variable_value, step_size, output ready);
endinterface

`default_nettype wire

FILE: design/irprop_minus_step_update.sv
// A result beat passes through S1, S2, S3 and the output register before it is presented.
// Throughput: one beat per cycle while out_ch.ready is high; an update whose
//   variable still has a beat in flight waits until that beat's write-back.
// Reset (rst_n low, synchronous): pipeline valids and config registers clear
//   to defaults; the state memory is not cleared, entries are set by a load.
`default_nettype none

module irprop_minus_step_update #(
  parameter int unsigned NUM_VARS = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  irp_in_if.sink                                   in_ch,
  irp_out_if.source                                out_ch,
  input  wire logic                                cfg_wr_en,
  input  wire logic [irp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [irp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int unsigned AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

  // ---------------------------------------------------------------
  // Config registers (to be written only while idle; the block does not enforce this)
  // ---------------------------------------------------------------
  irp_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.eta_plus  <= irp_pkg::ETA_PLUS_RST;
      cfg_r.eta_minus <= irp_pkg::ETA_MINUS_RST;
      cfg_r.step_min  <= irp_pkg::STEP_MIN_RST;
      cfg_r.step_max  <= irp_pkg::STEP_MAX_RST;
      cfg_r.step_init <= irp_pkg::STEP_INIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        irp_pkg::CFG_ETA_PLUS:  cfg_r.eta_plus  <= cfg_wdata[irp_pkg::ETA_W-1:0];
        irp_pkg::CFG_ETA_MINUS: cfg_r.eta_minus <= cfg_wdata[irp_pkg::ETA_W-1:0];
        irp_pkg::CFG_STEP_MIN:  cfg_r.step_min  <= cfg_wdata[irp_pkg::STEP_W-1:0];
        irp_pkg::CFG_STEP_MAX:  cfg_r.step_max  <= cfg_wdata[irp_pkg::STEP_W-1:0];
        irp_pkg::CFG_STEP_INIT: cfg_r.step_init <= cfg_wdata[irp_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Pipeline control
  //   S1: memory read data + beat payload, multiply
  //   S2: rescale and clamp step
  //   S3: move variable with saturation
  //   OUT: output register; write back to memory the cycle after load
  // All stages move together; the output register is the only place a
  // result waits, so the pipe advances whenever it is empty or drained.
  // ---------------------------------------------------------------
  irp_pkg::item_ctl_t               s1_ctl_r;
  irp_pkg::item_ctl_t               s2_ctl_r;
  irp_pkg::item_ctl_t               s3_ctl_r;
  irp_pkg::item_ctl_t               out_ctl_r;
  logic                             wb_pend_r;
  irp_pkg::action_t                 s1_action_r;
  logic signed [irp_pkg::VAL_W-1:0] s1_operand_r;

  logic                             adv;
  logic                             hazard;
  logic                             in_accept;
  logic                             in_range;
  irp_pkg::action_t                 in_action;
  irp_pkg::entry_t                  rd_entry;
  irp_pkg::entry_t                  s3_entry;
  irp_pkg::entry_t                  out_entry;

  assign adv       = !out_ctl_r.valid || out_ch.ready;
  assign in_action = irp_pkg::action_t'(in_ch.action);
  assign in_range  = 32'(in_ch.var_index) < 32'(NUM_VARS);

  // An update reads its entry at accept time, so no earlier beat may still
  // owe a write to that entry. Loads only write, and writes retire in order.
  always_comb begin
    hazard = 1'b0;
    if (in_action == irp_pkg::ACT_UPDATE) begin
      if (s1_ctl_r.valid && s1_ctl_r.wr && s1_ctl_r.idx == in_ch.var_index) begin
        hazard = 1'b1;
      end
      if (s2_ctl_r.valid && s2_ctl_r.wr && s2_ctl_r.idx == in_ch.var_index) begin
        hazard = 1'b1;
      end
      if (s3_ctl_r.valid && s3_ctl_r.wr && s3_ctl_r.idx == in_ch.var_index) begin
        hazard = 1'b1;
      end
      if (wb_pend_r && out_ctl_r.idx == in_ch.var_index) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_ch.ready = adv && !hazard;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r  <= '0;
      s2_ctl_r  <= '0;
      s3_ctl_r  <= '0;
      out_ctl_r <= '0;
      wb_pend_r <= 1'b0;
    end else begin
      // write-back is a single pulse right after the output register loads
      wb_pend_r <= adv && s3_ctl_r.valid && s3_ctl_r.wr;
      if (adv) begin
        s1_ctl_r.valid <= in_accept;
        s1_ctl_r.wr    <= in_range;
        s1_ctl_r.idx   <= in_ch.var_index;
        s2_ctl_r       <= s1_ctl_r;
        s3_ctl_r       <= s2_ctl_r;
        out_ctl_r      <= s3_ctl_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_action_r  <= in_action;
      s1_operand_r <= in_ch.operand_value;
    end
  end

  // ---------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------
  irp_state_mem #(
    .DEPTH (NUM_VARS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (AW'(in_ch.var_index)),
    .wr_en   (wb_pend_r),
    .wr_addr (AW'(out_ctl_r.idx)),
    .wr_data (out_entry),
    .rd_data (rd_entry)
  );

  irp_step_unit u_step (
    .clk         (clk),
    .adv         (adv),
    .cfg         (cfg_r),
    .s1_action   (s1_action_r),
    .s1_in_range (s1_ctl_r.wr),
    .s1_operand  (s1_operand_r),
    .rd_entry    (rd_entry),
    .s3_entry    (s3_entry)
  );

  irp_move_unit u_move (
    .clk       (clk),
    .adv       (adv),
    .s3_entry  (s3_entry),
    .out_entry (out_entry)
  );

  assign out_ch.valid          = out_ctl_r.valid;
  assign out_ch.out_index      = out_ctl_r.idx;
  assign out_ch.variable_value = out_entry.var_val;
  assign out_ch.step_size      = out_entry.step;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // a write-back always belongs to the beat sitting in the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    wb_pend_r |-> out_ctl_r.valid)
    else $error("write-back without a valid output beat");

  // out-of-range beats come back as zero value and zero step
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ctl_r.valid && !out_ctl_r.wr) |->
      (out_entry.var_val == '0 && out_entry.step == '0))
    else $error("out-of-range beat carries nonzero result");

  // the output register only fills from a valid third stage
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ctl_r.valid) |-> $past(s3_ctl_r.valid))
    else $error("output valid rose with empty third stage");

endmodule

`default_nettype wire

FILE: design/irp_state_mem.sv
`default_nettype none

module irp_state_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire irp_pkg::entry_t  wr_data,
  output irp_pkg::entry_t       rd_data
);

  irp_pkg::entry_t mem_r [DEPTH];
  irp_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: design/irp_step_unit.sv
`default_nettype none

module irp_step_unit (
  input  wire logic                             clk,
  input  wire logic                             adv,
  input  wire irp_pkg::cfg_t                    cfg,
  input  wire irp_pkg::action_t                 s1_action,
  input  wire logic                             s1_in_range,
  input  wire logic signed [irp_pkg::VAL_W-1:0] s1_operand,
  input  wire irp_pkg::entry_t                  rd_entry,
  output irp_pkg::entry_t                       s3_entry
);

  irp_pkg::sign_t                      cur_sign;
  irp_pkg::sign_t                      prev_sign;
  irp_pkg::sign_t                      mv_sign_nxt;
  irp_pkg::step_mode_t                 mode_nxt;
  logic [irp_pkg::ETA_W-1:0]           eta_sel;
  logic signed [irp_pkg::VAL_W-1:0]    var_nxt;
  logic [irp_pkg::STEP_W-1:0]          step_nxt;
  logic [irp_pkg::PROD_W-1:0]          prod_nxt;

  irp_pkg::step_mode_t                 s2_mode_r;
  irp_pkg::sign_t                      s2_sign_r;
  logic [irp_pkg::PROD_W-1:0]          s2_prod_r;
  logic [irp_pkg::STEP_W-1:0]          s2_step_r;
  logic signed [irp_pkg::VAL_W-1:0]    s2_var_r;

  logic [irp_pkg::SCALED_W-1:0]        scaled;
  logic [irp_pkg::STEP_W-1:0]          step_new;
  irp_pkg::entry_t                     s3_entry_r;

  // stage 1: pick base state, decide grow / shrink, multiply
  always_comb begin
    cur_sign    = irp_pkg::sign_of(s1_operand);
    prev_sign   = irp_pkg::sign_decode(rd_entry.sign_code);
    mode_nxt    = irp_pkg::MODE_HOLD;
    eta_sel     = cfg.eta_plus;
    var_nxt     = '0;
    step_nxt    = '0;
    mv_sign_nxt = irp_pkg::SIGN_ZERO;
    if (s1_in_range) begin
      if (s1_action == irp_pkg::ACT_LOAD) begin
        var_nxt  = s1_operand;
        step_nxt = cfg.step_init;
      end else begin
        var_nxt     = rd_entry.var_val;
        step_nxt    = rd_entry.step;
        mv_sign_nxt = cur_sign;
        if (cur_sign != irp_pkg::SIGN_ZERO && prev_sign != irp_pkg::SIGN_ZERO) begin
          if (cur_sign == prev_sign) begin
            mode_nxt = irp_pkg::MODE_GROW;
          end else begin
            mode_nxt    = irp_pkg::MODE_SHRINK;
            eta_sel     = cfg.eta_minus;
            mv_sign_nxt = irp_pkg::SIGN_ZERO;
          end
        end
      end
    end
    prod_nxt = irp_pkg::PROD_W'(step_nxt) * irp_pkg::PROD_W'(eta_sel);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mode_r <= mode_nxt;
      s2_sign_r <= mv_sign_nxt;
      s2_prod_r <= prod_nxt;
      s2_step_r <= step_nxt;
      s2_var_r  <= var_nxt;
    end
  end

  // stage 2: rescale and clamp the step
  assign scaled = s2_prod_r[irp_pkg::PROD_W-1:irp_pkg::ETA_FRAC];

  always_comb begin
    case (s2_mode_r)
      irp_pkg::MODE_GROW: begin
        if (scaled > irp_pkg::SCALED_W'(cfg.step_max)) begin
          step_new = cfg.step_max;
        end else begin
          step_new = scaled[irp_pkg::STEP_W-1:0];
        end
      end
      irp_pkg::MODE_SHRINK: begin
        if (scaled < irp_pkg::SCALED_W'(cfg.step_min)) begin
          step_new = cfg.step_min;
        end else if (scaled[irp_pkg::SCALED_W-1:irp_pkg::STEP_W] != '0) begin
          step_new = '1;
        end else begin
          step_new = scaled[irp_pkg::STEP_W-1:0];
        end
      end
      default: step_new = s2_step_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_entry_r.var_val   <= s2_var_r;
      s3_entry_r.step      <= step_new;
      s3_entry_r.sign_code <= s2_sign_r;
    end
  end

  assign s3_entry = s3_entry_r;

endmodule

`default_nettype wire

FILE: design/irp_move_unit.sv
`default_nettype none

module irp_move_unit (
  input  wire logic            clk,
  input  wire logic            adv,
  input  wire irp_pkg::entry_t s3_entry,
  output irp_pkg::entry_t      out_entry
);

  localparam int unsigned SUM_W = irp_pkg::VAL_W + 1;

  logic signed [SUM_W-1:0]          var_ext;
  logic signed [SUM_W-1:0]          step_ext;
  logic signed [SUM_W-1:0]          sum;
  logic signed [irp_pkg::VAL_W-1:0] var_new;
  irp_pkg::entry_t                  out_entry_r;

  assign var_ext  = {s3_entry.var_val[irp_pkg::VAL_W-1], s3_entry.var_val};
  assign step_ext = SUM_W'(s3_entry.step);

  always_comb begin
    case (irp_pkg::sign_decode(s3_entry.sign_code))
      irp_pkg::SIGN_POS: sum = var_ext - step_ext;
      irp_pkg::SIGN_NEG: sum = var_ext + step_ext;
      default:           sum = var_ext;
    endcase
    // saturate to the 48-bit range
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      var_new = sum[SUM_W-1] ? {1'b1, {(irp_pkg::VAL_W-1){1'b0}}}
                             : {1'b0, {(irp_pkg::VAL_W-1){1'b1}}};
    end else begin
      var_new = sum[irp_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_entry_r.var_val   <= var_new;
      out_entry_r.step      <= s3_entry.step;
      out_entry_r.sign_code <= s3_entry.sign_code;
    end
  end

  assign out_entry = out_entry_r;

endmodule

`default_nettype wire

FILE: dv/tb_irprop_minus_step_update.sv
`timescale 1ns / 100ps

module tb_irprop_minus_step_update;

  // ---------------------------------------------------------------------------
  // Local types
  // ---------------------------------------------------------------------------
  typedef struct packed {
    irp_pkg::action_t                 act;
    logic [irp_pkg::IDX_W-1:0]        idx;
    logic signed [irp_pkg::VAL_W-1:0] operand;
  } grad_beat_t;

  typedef struct packed {
    logic [irp_pkg::IDX_W-1:0]        idx;
    logic signed [irp_pkg::VAL_W-1:0] value;
    logic [irp_pkg::STEP_W-1:0]       step;
  } var_result_t;

  // receiver back-pressure patterns
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_mode_t;

  localparam logic signed [irp_pkg::VAL_W-1:0] VAL_TOP = {1'b0, {(irp_pkg::VAL_W-1){1'b1}}};
  localparam logic signed [irp_pkg::VAL_W-1:0] VAL_BOT = {1'b1, {(irp_pkg::VAL_W-1){1'b0}}};
  localparam logic [irp_pkg::STEP_W-1:0]       STEP_ALL1 = '1;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic                           clk;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [irp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [irp_pkg::CFG_DATA_W-1:0] cfg_wdata;

  irp_in_if  in_ch ();
  irp_out_if out_ch ();

  irprop_minus_step_update dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard state
  // ---------------------------------------------------------------------------
  grad_beat_t  pending_beats[$];     // beats waiting for the driver
  var_result_t expected_results[$];  // predicted results, oldest first
  int          err_cnt = 0;

  // Predictor's own copy of the optimizer state and register file
  irp_pkg::cfg_t                    opt_cfg;
  logic signed [irp_pkg::VAL_W-1:0] var_mem  [256];
  logic [irp_pkg::STEP_W-1:0]       step_mem [256];
  irp_pkg::sign_t                   sign_mem [256];

  // Stimulus bookkeeping: which entries hold a load, last gradient direction
  bit             loaded   [256];
  irp_pkg::sign_t last_dir [256];
  int             hot_base = 0;

  // ---------------------------------------------------------------------------
  // iRprop- predictor: one accepted beat -> one expected result
  // ---------------------------------------------------------------------------
  function automatic var_result_t irprop_apply(input grad_beat_t b);
    var_result_t                      r;
    irp_pkg::sign_t                   cur;
    irp_pkg::sign_t                   prev;
    logic [irp_pkg::STEP_W-1:0]       stp;
    logic signed [irp_pkg::VAL_W-1:0] v;
    logic [irp_pkg::PROD_W-1:0]       prod;
    logic [irp_pkg::PROD_W-1:0]       scaled;
    logic signed [irp_pkg::VAL_W:0]   moved;

    r.idx = b.idx;
    if (b.act == irp_pkg::ACT_LOAD) begin
      var_mem[b.idx]  = b.operand;
      step_mem[b.idx] = opt_cfg.step_init;
      sign_mem[b.idx] = irp_pkg::SIGN_ZERO;
    end else begin
      if (b.operand == '0)                  cur = irp_pkg::SIGN_ZERO;
      else if (b.operand[irp_pkg::VAL_W-1]) cur = irp_pkg::SIGN_NEG;
      else                                  cur = irp_pkg::SIGN_POS;
      prev = sign_mem[b.idx];
      stp  = step_mem[b.idx];
      v    = var_mem[b.idx];

      if (cur != irp_pkg::SIGN_ZERO && prev != irp_pkg::SIGN_ZERO) begin
        if (cur == prev) begin
          // same direction: grow, cap at step_max
          prod   = {{irp_pkg::ETA_W{1'b0}}, stp} *
                   {{irp_pkg::STEP_W{1'b0}}, opt_cfg.eta_plus};
          scaled = prod >> irp_pkg::ETA_FRAC;
          if (scaled > {{irp_pkg::ETA_W{1'b0}}, opt_cfg.step_max})
            scaled = {{irp_pkg::ETA_W{1'b0}}, opt_cfg.step_max};
          stp = scaled[irp_pkg::STEP_W-1:0];
        end else begin
          // sign flip: shrink, floor at step_min, clip to 32 bits, gradient dropped
          prod   = {{irp_pkg::ETA_W{1'b0}}, stp} *
                   {{irp_pkg::STEP_W{1'b0}}, opt_cfg.eta_minus};
          scaled = prod >> irp_pkg::ETA_FRAC;
          if (scaled < {{irp_pkg::ETA_W{1'b0}}, opt_cfg.step_min})
            scaled = {{irp_pkg::ETA_W{1'b0}}, opt_cfg.step_min};
          if (scaled > {{irp_pkg::ETA_W{1'b0}}, STEP_ALL1})
            scaled = {{irp_pkg::ETA_W{1'b0}}, STEP_ALL1};
          stp = scaled[irp_pkg::STEP_W-1:0];
          cur = irp_pkg::SIGN_ZERO;
        end
      end

      // move against the gradient, saturate to the 48-bit signed range
      if (cur != irp_pkg::SIGN_ZERO) begin
        if (cur == irp_pkg::SIGN_POS)
          moved = {v[irp_pkg::VAL_W-1], v} -
                  $signed({1'b0, {(irp_pkg::VAL_W-irp_pkg::STEP_W){1'b0}}, stp});
        else
          moved = {v[irp_pkg::VAL_W-1], v} +
                  $signed({1'b0, {(irp_pkg::VAL_W-irp_pkg::STEP_W){1'b0}}, stp});
        if (moved[irp_pkg::VAL_W] != moved[irp_pkg::VAL_W-1])
          v = moved[irp_pkg::VAL_W] ? VAL_BOT : VAL_TOP;
        else
          v = moved[irp_pkg::VAL_W-1:0];
      end

      var_mem[b.idx]  = v;
      step_mem[b.idx] = stp;
      sign_mem[b.idx] = cur;
    end
    r.value = var_mem[b.idx];
    r.step  = step_mem[b.idx];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps; predicts on acceptance
  // ---------------------------------------------------------------------------
  int         burst_left = 1;
  int         gap_left   = 0;
  grad_beat_t drv_beat;
  grad_beat_t taken_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken_beat.act     = irp_pkg::action_t'(in_ch.action);
        taken_beat.idx     = in_ch.var_index;
        taken_beat.operand = in_ch.operand_value;
        expected_results   = {expected_results, irprop_apply(taken_beat)};
      end

      if (in_ch.valid && !in_ch.ready) begin
        // beat still offered; hold everything
      end else if (gap_left != 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        drv_beat = pending_beats.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.action        <= drv_beat.act;
        in_ch.var_index     <= drv_beat.idx;
        in_ch.operand_value <= drv_beat.operand;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 32);
          // a quarter of the bursts run back to back with no idle cycle
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every result beat, drives ready from a changing pattern
  // ---------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int unsigned rdy_phase  = 0;
  var_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: out_index %0d", out_ch.out_index);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.out_index !== want.idx) begin
            $error("out_index: expected %0d, got %0d", want.idx, out_ch.out_index);
            err_cnt++;
          end
          if (out_ch.variable_value !== want.value) begin
            $error("variable_value: expected %0d, got %0d", want.value, out_ch.variable_value);
            err_cnt++;
          end
          if (out_ch.step_size !== want.step) begin
            $error("step_size: expected %0d, got %0d", want.step, out_ch.step_size);
            err_cnt++;
          end
        end
      end

      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        stall_left = $urandom_range(20, 150);
        rdy_phase  = $urandom_range(2, 5);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        STALL_NONE:     out_ch.ready <= 1'b1;
        STALL_RANDOM:   out_ch.ready <= 1'($urandom_range(0, 1));
        default:        out_ch.ready <= ((stall_left % rdy_phase) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [irp_pkg::VAL_W-1:0] rand_val();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[irp_pkg::VAL_W-1:0];
  endfunction

  task automatic add_beat(input irp_pkg::action_t act, input int idx,
                          input logic signed [irp_pkg::VAL_W-1:0] opv);
    grad_beat_t b;
    b.act     = act;
    b.idx     = idx[irp_pkg::IDX_W-1:0];
    b.operand = opv;
    if (act == irp_pkg::ACT_LOAD) loaded[b.idx] = 1'b1;
    pending_beats = {pending_beats, b};
  endtask

  // Register write at a rising edge; predictor copy follows at once (block idle)
  task automatic cfg_write(input irp_pkg::cfg_reg_t r,
                           input logic [irp_pkg::CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= d;
    case (r)
      irp_pkg::CFG_ETA_PLUS:  opt_cfg.eta_plus  = d[irp_pkg::ETA_W-1:0];
      irp_pkg::CFG_ETA_MINUS: opt_cfg.eta_minus = d[irp_pkg::ETA_W-1:0];
      irp_pkg::CFG_STEP_MIN:  opt_cfg.step_min  = d;
      irp_pkg::CFG_STEP_MAX:  opt_cfg.step_max  = d;
      irp_pkg::CFG_STEP_INIT: opt_cfg.step_init = d;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [irp_pkg::ETA_W-1:0] ep,
                            input logic [irp_pkg::ETA_W-1:0] em,
                            input logic [irp_pkg::STEP_W-1:0] smin,
                            input logic [irp_pkg::STEP_W-1:0] smax,
                            input logic [irp_pkg::STEP_W-1:0] sinit);
    cfg_write(irp_pkg::CFG_ETA_PLUS, {16'd0, ep});
    cfg_write(irp_pkg::CFG_ETA_MINUS, {16'd0, em});
    cfg_write(irp_pkg::CFG_STEP_MIN, smin);
    cfg_write(irp_pkg::CFG_STEP_MAX, smax);
    cfg_write(irp_pkg::CFG_STEP_INIT, sinit);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for the feed to empty and every result to land, then let the
  // four-stage pipe plus write-back settle before touching registers.
  task automatic drain();
    @(negedge clk);
    while (pending_beats.size() != 0 || in_ch.valid === 1'b1 ||
           expected_results.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // Random traffic: mostly gradient streams on a small hot set of entries so
  // same-index hazards and long sign runs (growth up to the cap) show up.
  task automatic queue_random(input int n);
    int                               idx;
    int                               pick;
    irp_pkg::sign_t                   dir;
    logic signed [irp_pkg::VAL_W-1:0] mag;
    logic signed [irp_pkg::VAL_W-1:0] opv;

    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) hot_base = $urandom_range(0, 255);
      if ($urandom_range(0, 1)) idx = (hot_base + $urandom_range(0, 3)) % 256;
      else                      idx = $urandom_range(0, 255);

      if (!loaded[idx] || $urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 2)      opv = VAL_TOP - $signed({16'd0, $urandom});
        else if (pick < 4) opv = VAL_BOT + $signed({16'd0, $urandom});
        else if (pick < 5) opv = '0;
        else               opv = rand_val();
        add_beat(irp_pkg::ACT_LOAD, idx, opv);
        last_dir[idx] = irp_pkg::SIGN_ZERO;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
          opv = '0;
        end else if (pick < 3) begin
          opv = $urandom_range(0, 1) ? VAL_TOP : VAL_BOT;
        end else if (pick < 5) begin
          opv = rand_val();
        end else begin
          // keep the previous direction most of the time
          if (last_dir[idx] != irp_pkg::SIGN_ZERO && $urandom_range(0, 99) < 65)
            dir = last_dir[idx];
          else
            dir = $urandom_range(0, 1) ? irp_pkg::SIGN_POS : irp_pkg::SIGN_NEG;
          mag = rand_val();
          mag[irp_pkg::VAL_W-1] = 1'b0;
          mag = mag >>> $urandom_range(0, 46);
          if (mag == '0) mag = 48'sd1;
          opv = (dir == irp_pkg::SIGN_NEG) ? -mag : mag;
        end
        if (opv != '0)
          last_dir[idx] = opv[irp_pkg::VAL_W-1] ? irp_pkg::SIGN_NEG : irp_pkg::SIGN_POS;
        add_beat(irp_pkg::ACT_UPDATE, idx, opv);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_index           = irp_pkg::CFG_ETA_PLUS;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.action        = irp_pkg::ACT_LOAD;
    in_ch.var_index     = '0;
    in_ch.operand_value = '0;
    out_ch.ready        = 1'b0;

    opt_cfg.eta_plus  = irp_pkg::ETA_PLUS_RST;
    opt_cfg.eta_minus = irp_pkg::ETA_MINUS_RST;
    opt_cfg.step_min  = irp_pkg::STEP_MIN_RST;
    opt_cfg.step_max  = irp_pkg::STEP_MAX_RST;
    opt_cfg.step_init = irp_pkg::STEP_INIT_RST;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset defaults: first update after load (no history), growth,
    // sign flip with gradient dropped, zero gradient, saturation both ways,
    // alternating bit patterns on the operand.
    add_beat(irp_pkg::ACT_LOAD,   0, '0);
    add_beat(irp_pkg::ACT_UPDATE, 0, 48'sd1);
    add_beat(irp_pkg::ACT_UPDATE, 0, VAL_TOP);
    add_beat(irp_pkg::ACT_UPDATE, 0, -48'sd1);
    add_beat(irp_pkg::ACT_UPDATE, 0, '0);
    add_beat(irp_pkg::ACT_UPDATE, 0, VAL_BOT);
    add_beat(irp_pkg::ACT_UPDATE, 0, -48'sd3);
    add_beat(irp_pkg::ACT_LOAD,   255, VAL_TOP);
    add_beat(irp_pkg::ACT_UPDATE, 255, -48'sd7);
    add_beat(irp_pkg::ACT_LOAD,   128, VAL_BOT);
    add_beat(irp_pkg::ACT_UPDATE, 128, 48'sd7);
    add_beat(irp_pkg::ACT_LOAD,   8'h55, 48'sh5555_5555_5555);
    add_beat(irp_pkg::ACT_LOAD,   8'hAA, 48'shAAAA_AAAA_AAAA);
    drain();

    // Directed, top extremes: growth capped at all-ones, shrink with
    // eta_minus above one clipped to 32 bits, move saturating near the top.
    set_config(16'hFFFF, 16'hFFFF, '0, STEP_ALL1, STEP_ALL1);
    add_beat(irp_pkg::ACT_LOAD,   1, '0);
    add_beat(irp_pkg::ACT_UPDATE, 1, 48'sd1);
    add_beat(irp_pkg::ACT_UPDATE, 1, 48'sd1);
    add_beat(irp_pkg::ACT_UPDATE, 1, -48'sd1);
    add_beat(irp_pkg::ACT_UPDATE, 1, -48'sd1);
    add_beat(irp_pkg::ACT_LOAD,   2, VAL_TOP - 48'sd1);
    add_beat(irp_pkg::ACT_UPDATE, 2, -48'sd1);
    drain();

    // Directed, zero etas: growth collapses to zero, shrink floors at step_min
    set_config(16'h0000, 16'h0000, STEP_ALL1, '0, 32'd5);
    add_beat(irp_pkg::ACT_LOAD,   3, '0);
    add_beat(irp_pkg::ACT_UPDATE, 3, 48'sd1);
    add_beat(irp_pkg::ACT_UPDATE, 3, 48'sd1);
    add_beat(irp_pkg::ACT_UPDATE, 3, -48'sd1);
    drain();

    // Random phases, each under its own register setting; every drain is a
    // full pause of the feed until all results are back.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(irp_pkg::ETA_PLUS_RST, irp_pkg::ETA_MINUS_RST, irp_pkg::STEP_MIN_RST,
                      irp_pkg::STEP_MAX_RST, irp_pkg::STEP_INIT_RST);
        1: set_config(16'hFFFF, 16'hFFFF, '0, STEP_ALL1, $urandom);
        2: set_config(16'h0000, 16'h0000, STEP_ALL1, '0, STEP_ALL1);
        3: set_config(16'd24576, 16'd4096, 32'd1024, 32'h1000_0000, 32'h0100_0000);
        default: set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            $urandom_range(0, 65535), $urandom, $urandom);
      endcase
      queue_random(230);
      drain();
    end

    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this traffic
  initial begin
    #(10_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
design/irp_pkg.sv
design/irp_in_if.sv
design/irp_out_if.sv
design/irp_state_mem.sv
design/irp_step_unit.sv
design/irp_move_unit.sv
design/irprop_minus_step_update.sv
dv/tb_irprop_minus_step_update.sv
